### src/memory_attach_register_block_defines.svh
// Assertion macros of the memory attach register block checker.
// Depends on nothing; included by the checker file only.
`ifndef MEMORY_ATTACH_REGISTER_BLOCK_DEFINES_SVH
`define MEMORY_ATTACH_REGISTER_BLOCK_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MAB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("mab: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define MAB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("mab: next-cycle check failed");

`endif

### src/mab_pkg.sv
// Shared types and constants of the memory attach register block.
// Depends on nothing; imported by memory_attach_register_block and mab_regs.
package mab_pkg;

    localparam int DEF_WINDOW_BYTES = 4096;
    localparam int OFS_W            = 12;
    localparam int PADDR_W          = 3;
    localparam int STATUS_W         = 5;

    // Register window offsets
    localparam logic [OFS_W-1:0] OFS_MASK     = 12'd0;
    localparam logic [OFS_W-1:0] OFS_STATUS   = 12'd4;
    localparam logic [OFS_W-1:0] OFS_DOORBELL = 12'd8;
    localparam logic [OFS_W-1:0] OFS_ALIGN    = 12'd12;
    localparam logic [OFS_W-1:0] OFS_MAP_LO   = 12'd16;
    localparam logic [OFS_W-1:0] OFS_MAP_HI   = 12'd20;
    localparam logic [OFS_W-1:0] OFS_SIZE_LO  = 12'd24;
    localparam logic [OFS_W-1:0] OFS_SIZE_HI  = 12'd28;
    localparam logic [OFS_W-1:0] OFS_SRC_LO   = 12'd32;
    localparam logic [OFS_W-1:0] OFS_SRC_HI   = 12'd36;

    // Status bits
    localparam logic [STATUS_W-1:0] ST_ATTACH_OK  = 5'b00001;
    localparam logic [STATUS_W-1:0] ST_DETACH_OK  = 5'b00010;
    localparam logic [STATUS_W-1:0] ST_ATTACH_ERR = 5'b01000;

    // Doorbell command fields
    localparam int                CMD_ENABLE_BIT = 31;
    localparam logic [15:0]       CMD_ATTACH     = 16'd1;
    localparam logic [15:0]       CMD_DETACH     = 16'd2;

    localparam logic KIND_WRITE = 1'b1;

    // Configuration register indexes (APB word address)
    localparam logic CFG_ALIGN   = 1'b0;
    localparam logic CFG_BACKING = 1'b1;

    localparam logic [31:0] ALIGN_RESET = 32'h4000_0000;

    typedef struct packed {
        logic             kind;
        logic [OFS_W-1:0] byte_offset;
        logic             access_wide;
        logic [63:0]      write_data;
    } t_access;

    typedef struct packed {
        logic [31:0] align_bytes;
        logic        backing_present;
    } t_cfg;

    typedef struct packed {
        logic [63:0] read_data;
        logic        irq_pulse;
    } t_result;

endpackage

### src/memory_attach_register_block.sv
// Top level of the memory attach register block: bus beat stages and APB config port.
// Depends on mab_pkg and mab_regs.
// A beat taken into the input register is executed as it moves to the result register,
//   which then offers its result beat.
// Throughput: one beat per cycle while the consumer takes responses.
// Reset: synchronous, active low; clears both stages, restores registers, status = detach done.
module memory_attach_register_block #(
    parameter int WINDOW_BYTES = mab_pkg::DEF_WINDOW_BYTES
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // request beats
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_kind,
    input  logic [mab_pkg::OFS_W-1:0]   i_byte_offset,
    input  logic                        i_access_wide,
    input  logic [63:0]                 i_write_data,
    // response beats
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [63:0]                 o_read_data,
    output logic                        o_irq_pulse,
    // APB configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mab_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import mab_pkg::*;

    // Input stage: hold one request beat until the result stage can take it.
    logic    r_in_valid;
    t_access r_in;
    // Result stage: hold the response until the consumer takes it.
    logic    r_out_valid;
    t_result r_out;

    t_cfg    r_cfg;
    t_result res;
    logic    out_load;
    logic    fire;
    logic    in_load;
    logic    cfg_wr;

    // Result register frees up when empty or when its beat leaves this cycle.
    assign out_load = !r_out_valid || i_ready;
    // Execute the held beat as it moves to the result register; state updates then.
    assign fire     = r_in_valid && out_load;
    // Input register takes a new beat when empty or being drained.
    assign o_ready  = !r_in_valid || out_load;
    assign in_load  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_in.kind        <= i_kind;
            r_in.byte_offset <= i_byte_offset;
            r_in.access_wide <= i_access_wide;
            r_in.write_data  <= i_write_data;
        end
    end

    mab_regs #(
        .WINDOW_BYTES (WINDOW_BYTES)
    ) u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_acc   (r_in),
        .i_cfg   (r_cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= res;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_read_data = r_out.read_data;
    assign o_irq_pulse = r_out.irq_pulse;

    // APB: no wait states; word select by paddr[2], low bits ignored.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.align_bytes     <= ALIGN_RESET;
            r_cfg.backing_present <= 1'b1;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                CFG_ALIGN:   r_cfg.align_bytes     <= pwdata;
                CFG_BACKING: r_cfg.backing_present <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            CFG_ALIGN:   prdata = r_cfg.align_bytes;
            CFG_BACKING: prdata = {31'h0, r_cfg.backing_present};
            default:     prdata = '0;
        endcase
    end

endmodule

### src/mab_regs.sv
// Register file and doorbell command logic of the memory attach block.
// Depends on mab_pkg.
module mab_regs #(
    parameter int WINDOW_BYTES = mab_pkg::DEF_WINDOW_BYTES
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  mab_pkg::t_access i_acc,
    input  mab_pkg::t_cfg    i_cfg,
    output mab_pkg::t_result o_res
);
    import mab_pkg::*;

    logic [31:0]         r_mask,   n_mask;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [63:0]         r_size,   n_size;
    logic [63:0]         r_src,    n_src;
    logic [63:0]         r_map,    n_map;

    logic        in_win;
    logic [63:0] data;
    logic [31:0] gmask;
    logic        attach_bad;
    logic [63:0] rdata;
    logic        irq;

    always_comb begin
        n_mask   = r_mask;
        n_status = r_status;
        n_size   = r_size;
        n_src    = r_src;
        n_map    = r_map;
        rdata    = '0;
        irq      = 1'b0;

        in_win = (32'(i_acc.byte_offset) < 32'(WINDOW_BYTES));
        data   = i_acc.access_wide ? i_acc.write_data : {32'h0, i_acc.write_data[31:0]};
        gmask  = i_cfg.align_bytes - 32'd1;
        attach_bad = (r_size == 64'd0) || !i_cfg.backing_present ||
                     ((r_size[31:0] & gmask) != 32'd0) ||
                     ((r_map[31:0] & gmask) != 32'd0);

        if (in_win) begin
            if (i_acc.kind == KIND_WRITE) begin
                unique case (i_acc.byte_offset)
                    OFS_MASK: begin
                        n_mask = data[31:0];
                    end
                    OFS_DOORBELL: begin
                        if (data[CMD_ENABLE_BIT]) begin
                            if (data[15:0] == CMD_ATTACH) begin
                                irq = 1'b1;
                                if (attach_bad) begin
                                    n_status = r_status | ST_ATTACH_ERR;
                                end else begin
                                    n_map    = r_map + r_size;
                                    n_status = r_status | ST_ATTACH_OK;
                                end
                            end else if (data[15:0] == CMD_DETACH) begin
                                irq      = 1'b1;
                                n_map    = '0;
                                n_status = r_status | ST_DETACH_OK;
                            end
                        end
                    end
                    OFS_SIZE_LO: begin
                        n_size = i_acc.access_wide ? data : {r_size[63:32], data[31:0]};
                    end
                    OFS_SIZE_HI: begin
                        n_size = {data[31:0], r_size[31:0]};
                    end
                    OFS_SRC_LO: begin
                        n_src = i_acc.access_wide ? data : {r_src[63:32], data[31:0]};
                    end
                    OFS_SRC_HI: begin
                        n_src = {data[31:0], r_src[31:0]};
                    end
                    default: begin
                    end
                endcase
            end else begin
                unique case (i_acc.byte_offset)
                    OFS_MASK:    rdata = {32'h0, r_mask};
                    OFS_STATUS: begin
                        rdata    = {59'h0, r_status};
                        n_status = '0;
                    end
                    OFS_ALIGN:   rdata = {32'h0, i_cfg.align_bytes};
                    OFS_MAP_LO:  rdata = r_map;
                    OFS_MAP_HI:  rdata = {32'h0, r_map[63:32]};
                    OFS_SIZE_LO: rdata = r_size;
                    OFS_SIZE_HI: rdata = {32'h0, r_size[63:32]};
                    OFS_SRC_LO:  rdata = r_src;
                    OFS_SRC_HI:  rdata = {32'h0, r_src[63:32]};
                    default:     rdata = '0;
                endcase
                if (!i_acc.access_wide) begin
                    rdata[63:32] = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask   <= '0;
            r_status <= ST_DETACH_OK;
            r_size   <= '0;
            r_src    <= '0;
            r_map    <= '0;
        end else if (i_fire) begin
            r_mask   <= n_mask;
            r_status <= n_status;
            r_size   <= n_size;
            r_src    <= n_src;
            r_map    <= n_map;
        end
    end

    assign o_res.read_data = rdata;
    assign o_res.irq_pulse = irq;

endmodule

### src/mab_checker.sv
// Port-level checker of the memory attach register block, bound to the top level.
// Depends on memory_attach_register_block_defines.svh and memory_attach_register_block.
`include "memory_attach_register_block_defines.svh"

module mab_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [63:0] o_read_data,
    input logic        o_irq_pulse,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] prdata
);

    // A held response must not change while the consumer stalls.
    `MAB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_read_data) && $stable(o_irq_pulse))

    // Interrupts come only from doorbell writes, and writes return zero data.
    `MAB_ASSERT_NOW(a_irq_zero_data, i_clk, i_rst_n, o_valid && o_irq_pulse, o_read_data == 64'h0)

    // An empty result stage means both stages can move, so requests are taken.
    `MAB_ASSERT_NOW(a_ready_when_empty, i_clk, i_rst_n, !o_valid, o_ready)

    // Backing flag reads back as a single bit.
    `MAB_ASSERT_NOW(a_backing_one_bit, i_clk, i_rst_n, psel && penable && !pwrite && paddr[2], prdata[31:1] == 31'h0)

endmodule

bind memory_attach_register_block mab_checker u_mab_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_ready     (o_ready),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_read_data (o_read_data),
    .o_irq_pulse (o_irq_pulse),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .prdata      (prdata)
);
